>>> rtl/core/fwr3_pkg.sv
// Shared types, constants and helpers for the 3D full-weighting restriction block.
// No dependencies; every other file but fwr3_ram refers to this package by scoped names.
`default_nettype none

package fwr3_pkg;

    // Grid limits and field widths
    localparam int MAX_COARSE = 64;
    localparam int CNT_W      = 7;
    localparam int POS_W      = CNT_W + 1;
    localparam int IDX_W      = $clog2(MAX_COARSE);
    localparam int SAMPLE_W   = 32;
    localparam int ZS_W       = SAMPLE_W + 2;
    localparam int ROW_W      = ZS_W + 2;
    localparam int PLANE_W    = ROW_W + 2;
    localparam int ROUND_SH   = 6;

    // Store depths
    localparam int ROW_DEPTH   = MAX_COARSE;
    localparam int PLANE_DEPTH = MAX_COARSE * MAX_COARSE;
    localparam int PLANE_AW    = 2 * IDX_W;

    // Queue sizes
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_Z = 2'd2;

    // Operation on the row accumulator (chosen by fine y)
    typedef enum logic [1:0] {
        ROW_INIT,
        ROW_ADD,
        ROW_CLOSE
    } row_op_t;

    // Operation on the plane accumulator (chosen by fine x)
    typedef enum logic [1:0] {
        PLANE_INIT,
        PLANE_ADD,
        PLANE_EMIT
    } plane_op_t;

    // One classified transaction passed from front to back
    typedef struct packed {
        logic signed [ZS_W-1:0] zs;
        logic [IDX_W-1:0]       k;
        logic [IDX_W-1:0]       j;
        row_op_t                row_op;
        plane_op_t              plane_op;
        logic                   done;
    } cmd_t;

    // Clamp a written count to the supported range
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > CNT_W'(MAX_COARSE))
            r = CNT_W'(MAX_COARSE);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/full_weighting_restriction_3d.sv
// Top level of the 27-point full-weighting restriction of a 3D fine grid.
// Depends on fwr3_pkg, fwr3_front, fwr3_cmd_queue and fwr3_back.
//
// Usage:
//   Fine samples enter on push/full in raster order (x outer, z fastest), one
//   per cycle while full is low, no gaps required. Coarse values leave on
//   empty/pop in coarse raster order; grid_done marks the last value of a grid.
//   The coarse counts are set through cfg_we/cfg_index/cfg_data while idle;
//   a count register write returns the fine position to the grid origin.
// Throughput: one fine sample per cycle while full is low, set by the single
//   read-modify-write per even-z sample on the row store, and at even y on
//   the plane store. The fine sample that completes a 3x3x3 block passes
//   the command queue, stage B and stage C before its value is queued.
// Reset: counts return to 64, the position to the origin and both queues empty;
//   the stores need no clearing, as each entry is written before it is read.
// Stall: while the receiver holds pop low, results collect in a four-entry
//   queue; once it is committed, classified transactions pile up in a
//   four-entry queue and full rises when that is full.
`default_nettype none

module full_weighting_restriction_3d (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [fwr3_pkg::SAMPLE_W-1:0] fine_sample,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [fwr3_pkg::SAMPLE_W-1:0]      coarse_value,
    output logic                                      grid_done,
    input  wire logic                                 cfg_we,
    input  wire logic [fwr3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [fwr3_pkg::CNT_W-1:0]           cfg_data
);

    logic           enq;
    fwr3_pkg::cmd_t enq_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    fwr3_pkg::cmd_t q_cmd;

    assign full = q_full;

    // Accept and classify
    fwr3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .fine_sample (fine_sample),
        .q_full      (q_full),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .enq         (enq),
        .enq_cmd     (enq_cmd)
    );

    // Decouple front from back
    fwr3_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (enq),
        .wr_cmd (enq_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_cmd (q_cmd),
        .valid  (q_valid)
    );

    // Accumulate, round and queue results
    fwr3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .coarse_value (coarse_value),
        .grid_done    (grid_done)
    );

endmodule

`default_nettype wire

>>> rtl/core/fwr3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module fwr3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/fwr3_front.sv
// Front end: accepts fine samples, tracks the fine position, filters along z and
// classifies each transaction for the back end. Depends on fwr3_pkg.
`default_nettype none

module fwr3_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic signed [fwr3_pkg::SAMPLE_W-1:0] fine_sample,
    input  wire logic                              q_full,
    input  wire logic                              cfg_we,
    input  wire logic [fwr3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fwr3_pkg::CNT_W-1:0]        cfg_data,
    output logic                                   enq,
    output fwr3_pkg::cmd_t                         enq_cmd
);

    logic [fwr3_pkg::CNT_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [fwr3_pkg::POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [fwr3_pkg::POS_W-1:0] px_next, py_next, pz_next;
    logic signed [fwr3_pkg::SAMPLE_W-1:0] zp0_reg, zp1_reg;
    logic [fwr3_pkg::POS_W-1:0] x_last, y_last, z_last;
    logic [fwr3_pkg::POS_W-2:0] k_full, j_full;
    logic accept;
    logic cfg_hit;

    assign accept  = push && !q_full;
    assign cfg_hit = cfg_we && (cfg_index == fwr3_pkg::REG_COARSE_X
                             || cfg_index == fwr3_pkg::REG_COARSE_Y
                             || cfg_index == fwr3_pkg::REG_COARSE_Z);

    // Last fine index on each axis is twice the coarse count
    assign x_last = {cx_reg, 1'b0};
    assign y_last = {cy_reg, 1'b0};
    assign z_last = {cz_reg, 1'b0};

    // Advance the fine position, z fastest; a register write returns to the origin
    always_comb
    begin
        px_next = px_reg;
        py_next = py_reg;
        pz_next = pz_reg;
        if (cfg_hit)
        begin
            px_next = '0;
            py_next = '0;
            pz_next = '0;
        end
        else if (accept)
        begin
            if (pz_reg == z_last)
            begin
                pz_next = '0;
                if (py_reg == y_last)
                begin
                    py_next = '0;
                    px_next = (px_reg == x_last) ? '0 : px_reg + 1'b1;
                end
                else
                begin
                    py_next = py_reg + 1'b1;
                end
            end
            else
            begin
                pz_next = pz_reg + 1'b1;
            end
        end
    end

    // Classify: coarse indexes, z-filtered sum and accumulator operations
    assign k_full = pz_reg[fwr3_pkg::POS_W-1:1] - 1'b1;
    assign j_full = py_reg[fwr3_pkg::POS_W-1:1] - 1'b1;

    always_comb
    begin
        enq_cmd.zs = fwr3_pkg::ZS_W'(zp0_reg) + (fwr3_pkg::ZS_W'(zp1_reg) <<< 1)
                   + fwr3_pkg::ZS_W'(fine_sample);
        enq_cmd.k  = k_full[fwr3_pkg::IDX_W-1:0];
        enq_cmd.j  = j_full[fwr3_pkg::IDX_W-1:0];
        if (py_reg == '0)
            enq_cmd.row_op = fwr3_pkg::ROW_INIT;
        else if (py_reg[0])
            enq_cmd.row_op = fwr3_pkg::ROW_ADD;
        else
            enq_cmd.row_op = fwr3_pkg::ROW_CLOSE;
        if (px_reg == '0)
            enq_cmd.plane_op = fwr3_pkg::PLANE_INIT;
        else if (px_reg[0])
            enq_cmd.plane_op = fwr3_pkg::PLANE_ADD;
        else
            enq_cmd.plane_op = fwr3_pkg::PLANE_EMIT;
        enq_cmd.done = (px_reg == x_last) && (py_reg == y_last) && (pz_reg == z_last);
    end

    // Only even z past the first pair closes a z triple
    assign enq = accept && (pz_reg[fwr3_pkg::POS_W-1:1] != '0) && !pz_reg[0];

    // Hold counts and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= fwr3_pkg::CNT_W'(fwr3_pkg::MAX_COARSE);
            cy_reg <= fwr3_pkg::CNT_W'(fwr3_pkg::MAX_COARSE);
            cz_reg <= fwr3_pkg::CNT_W'(fwr3_pkg::MAX_COARSE);
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == fwr3_pkg::REG_COARSE_X)
                cx_reg <= fwr3_pkg::clamp_count(cfg_data);
            if (cfg_we && cfg_index == fwr3_pkg::REG_COARSE_Y)
                cy_reg <= fwr3_pkg::clamp_count(cfg_data);
            if (cfg_we && cfg_index == fwr3_pkg::REG_COARSE_Z)
                cz_reg <= fwr3_pkg::clamp_count(cfg_data);
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    // Shift the previous two samples along z
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            zp0_reg <= zp1_reg;
            zp1_reg <= fine_sample;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fwr3_cmd_queue.sv
// Short queue of classified transactions between front and back end.
// Depends on fwr3_pkg.
`default_nettype none

module fwr3_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire fwr3_pkg::cmd_t wr_cmd,
    output logic                full,
    input  wire logic           rd_en,
    output fwr3_pkg::cmd_t      rd_cmd,
    output logic                valid
);

    fwr3_pkg::cmd_t mem_reg [fwr3_pkg::CMD_DEPTH];
    logic [fwr3_pkg::CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fwr3_pkg::CMD_PTR_W:0]   count_reg;
    logic do_wr, do_rd;

    assign full   = (count_reg == (fwr3_pkg::CMD_PTR_W+1)'(fwr3_pkg::CMD_DEPTH));
    assign valid  = (count_reg != '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;
    assign rd_cmd = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/core/fwr3_back.sv
// Back end: y and x accumulation through row and plane stores, rounding and the
// result queue. Depends on fwr3_pkg and fwr3_ram.
`default_nettype none

module fwr3_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cmd_valid,
    input  wire fwr3_pkg::cmd_t                       cmd,
    output logic                                      cmd_pop,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [fwr3_pkg::SAMPLE_W-1:0]      coarse_value,
    output logic                                      grid_done
);

    typedef struct packed {
        logic signed [fwr3_pkg::SAMPLE_W-1:0] value;
        logic                                 done;
    } res_t;

    // Stage B: row read-modify-write
    logic           b_valid_reg;
    fwr3_pkg::cmd_t b_cmd_reg;
    logic [fwr3_pkg::ROW_W-1:0] row_rdata;
    logic signed [fwr3_pkg::ROW_W-1:0] row_val, zs_ext, row_wdata, ys;
    logic           row_fwd_valid_reg;
    logic [fwr3_pkg::IDX_W-1:0] row_fwd_addr_reg;
    logic signed [fwr3_pkg::ROW_W-1:0] row_fwd_data_reg;
    logic           plane_req;

    // Stage C: plane read-modify-write and rounding
    logic           c_valid_reg;
    fwr3_pkg::plane_op_t c_op_reg;
    logic           c_done_reg;
    logic signed [fwr3_pkg::ROW_W-1:0] c_ys_reg;
    logic [fwr3_pkg::PLANE_AW-1:0] c_addr_reg;
    logic [fwr3_pkg::PLANE_W-1:0] plane_rdata;
    logic signed [fwr3_pkg::PLANE_W-1:0] plane_val, ys_ext, plane_wdata, total;
    logic signed [fwr3_pkg::PLANE_W:0] biased;
    logic           plane_fwd_valid_reg;
    logic [fwr3_pkg::PLANE_AW-1:0] plane_fwd_addr_reg;
    logic signed [fwr3_pkg::PLANE_W-1:0] plane_fwd_data_reg;
    logic           res_push;

    // Result queue
    res_t res_mem_reg [fwr3_pkg::RES_DEPTH];
    logic [fwr3_pkg::RES_PTR_W-1:0] res_wr_ptr_reg, res_rd_ptr_reg;
    logic [fwr3_pkg::RES_PTR_W:0]   res_count_reg;
    logic [fwr3_pkg::RES_PTR_W+1:0] committed;
    logic res_pop;

    // Issue only when every transaction in flight is sure of a result slot
    assign committed = (fwr3_pkg::RES_PTR_W+2)'(res_count_reg)
                     + (fwr3_pkg::RES_PTR_W+2)'(b_valid_reg)
                     + (fwr3_pkg::RES_PTR_W+2)'(c_valid_reg);
    assign cmd_pop = cmd_valid
                  && (committed < (fwr3_pkg::RES_PTR_W+2)'(fwr3_pkg::RES_DEPTH));

    fwr3_ram #(
        .WIDTH (fwr3_pkg::ROW_W),
        .DEPTH (fwr3_pkg::ROW_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_cmd_reg.k),
        .wdata (row_wdata),
        .raddr (cmd.k),
        .rdata (row_rdata)
    );

    // Row accumulate; forward the write made in the previous cycle
    always_comb
    begin
        zs_ext  = fwr3_pkg::ROW_W'(b_cmd_reg.zs);
        row_val = (row_fwd_valid_reg && row_fwd_addr_reg == b_cmd_reg.k)
                ? row_fwd_data_reg : $signed(row_rdata);
        ys      = row_val + zs_ext;
        unique case (b_cmd_reg.row_op)
            fwr3_pkg::ROW_INIT:  row_wdata = zs_ext;
            fwr3_pkg::ROW_ADD:   row_wdata = row_val + (zs_ext <<< 1);
            fwr3_pkg::ROW_CLOSE: row_wdata = zs_ext;
            default:             row_wdata = zs_ext;
        endcase
    end

    assign plane_req = b_valid_reg && (b_cmd_reg.row_op == fwr3_pkg::ROW_CLOSE);

    fwr3_ram #(
        .WIDTH (fwr3_pkg::PLANE_W),
        .DEPTH (fwr3_pkg::PLANE_DEPTH)
    ) u_plane_store (
        .clk   (clk),
        .we    (c_valid_reg),
        .waddr (c_addr_reg),
        .wdata (plane_wdata),
        .raddr ({b_cmd_reg.j, b_cmd_reg.k}),
        .rdata (plane_rdata)
    );

    // Plane accumulate and round half up on the closing sample
    always_comb
    begin
        ys_ext    = fwr3_pkg::PLANE_W'(c_ys_reg);
        plane_val = (plane_fwd_valid_reg && plane_fwd_addr_reg == c_addr_reg)
                  ? plane_fwd_data_reg : $signed(plane_rdata);
        total     = plane_val + ys_ext;
        unique case (c_op_reg)
            fwr3_pkg::PLANE_INIT: plane_wdata = ys_ext;
            fwr3_pkg::PLANE_ADD:  plane_wdata = plane_val + (ys_ext <<< 1);
            fwr3_pkg::PLANE_EMIT: plane_wdata = ys_ext;
            default:              plane_wdata = ys_ext;
        endcase
        biased = (fwr3_pkg::PLANE_W+1)'(total)
               + (fwr3_pkg::PLANE_W+1)'(1 << (fwr3_pkg::ROUND_SH - 1));
    end

    assign res_push = c_valid_reg && (c_op_reg == fwr3_pkg::PLANE_EMIT);
    assign res_pop  = pop && !empty;
    assign empty    = (res_count_reg == '0);
    assign coarse_value = res_mem_reg[res_rd_ptr_reg].value;
    assign grid_done    = res_mem_reg[res_rd_ptr_reg].done;

    // Pipeline control and result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg         <= 1'b0;
            c_valid_reg         <= 1'b0;
            row_fwd_valid_reg   <= 1'b0;
            plane_fwd_valid_reg <= 1'b0;
            res_wr_ptr_reg      <= '0;
            res_rd_ptr_reg      <= '0;
            res_count_reg       <= '0;
        end
        else
        begin
            b_valid_reg         <= cmd_pop;
            c_valid_reg         <= plane_req;
            row_fwd_valid_reg   <= b_valid_reg;
            plane_fwd_valid_reg <= c_valid_reg;
            if (res_push)
                res_wr_ptr_reg <= res_wr_ptr_reg + 1'b1;
            if (res_pop)
                res_rd_ptr_reg <= res_rd_ptr_reg + 1'b1;
            if (res_push && !res_pop)
                res_count_reg <= res_count_reg + 1'b1;
            else if (res_pop && !res_push)
                res_count_reg <= res_count_reg - 1'b1;
        end
    end

    // Pipeline payload, forwarding data and result entries
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            b_cmd_reg <= cmd;
        c_op_reg           <= b_cmd_reg.plane_op;
        c_done_reg         <= b_cmd_reg.done;
        c_ys_reg           <= ys;
        c_addr_reg         <= {b_cmd_reg.j, b_cmd_reg.k};
        row_fwd_addr_reg   <= b_cmd_reg.k;
        row_fwd_data_reg   <= row_wdata;
        plane_fwd_addr_reg <= c_addr_reg;
        plane_fwd_data_reg <= plane_wdata;
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg].value <=
                biased[fwr3_pkg::ROUND_SH+fwr3_pkg::SAMPLE_W-1:fwr3_pkg::ROUND_SH];
            res_mem_reg[res_wr_ptr_reg].done <= c_done_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fwr3_checker.sv
// Port-level checks for full_weighting_restriction_3d, attached by bind.
// Depends on fwr3_pkg.
`default_nettype none

module fwr3_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 push,
    input wire logic                                 full,
    input wire logic                                 empty,
    input wire logic                                 pop,
    input wire logic signed [fwr3_pkg::SAMPLE_W-1:0] coarse_value,
    input wire logic                                 grid_done
);

    logic pushed_reg;

    // Note any accepted sample since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pushed_reg <= 1'b0;
        else if (push && !full)
            pushed_reg <= 1'b1;
    end

    // Hold a waiting result while the receiver stalls
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(coarse_value) && $stable(grid_done))
        else $error("waiting result changed while stalled");

    // Leave reset with both sides open and nothing to deliver
    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty && !full)
        else $error("block not empty and ready after reset");

    // No result before a sample has gone through the pipeline
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $past(pushed_reg, 2))
        else $error("result appeared without an earlier transaction");

endmodule

bind full_weighting_restriction_3d fwr3_checker u_fwr3_checker (.*);

`default_nettype wire
